>>> rtl/ebdp_pkg.sv
// Package for the balanced drive pulser: pattern kind and phase types,
// and the configuration register indexes and operation codes. No dependencies.
`default_nettype none

package ebdp_pkg;

  // Which motors a pattern drives.
  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_LEFT  = 2'd1,
    KIND_RIGHT = 2'd2,
    KIND_BOTH  = 2'd3
  } kind_t;

  // Phase of the running pattern, one-hot.
  typedef enum logic [3:0] {
    PH_BOUNDARY = 4'b0001,
    PH_ON       = 4'b0010,
    PH_OFF      = 4'b0100,
    PH_GAP      = 4'b1000
  } phase_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_EVEN_ON    = 3'd0;
  localparam logic [2:0] REG_EVEN_OFF   = 3'd1;
  localparam logic [2:0] REG_UNEVEN_ON  = 3'd2;
  localparam logic [2:0] REG_UNEVEN_OFF = 3'd3;
  localparam logic [2:0] REG_GAP        = 3'd4;
  localparam logic [2:0] REG_AVOID      = 3'd5;

  // Operation codes of an input item.
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

endpackage

`default_nettype wire

>>> rtl/encoder_balanced_drive_pulser.sv
// An accepted item's result is in the output register in the cycle after it is accepted.
// Throughput: one item per cycle; the state update is a single pass of logic
// between the input ports and the output register, which keeps accepting
// while a held result is taken in the same cycle.
// Reset (rst, synchronous): no move active, counts and timers cleared,
// configuration registers back to their defaults, no result pending.
`default_nettype none

module encoder_balanced_drive_pulser
  import ebdp_pkg::*;
#(
  parameter int STEP_BITS = 16,
  parameter int TIME_BITS = 20
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input item channel.
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        op,
  input  wire logic [19:0] duration_ms,
  input  wire logic        gate_left,
  input  wire logic        gate_right,
  input  wire logic        obstacle,
  // Result channel.
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             motor_left,
  output logic             motor_right,
  output logic             busy_res,
  output logic             done_res,
  // Configuration write channel.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  localparam logic [STEP_BITS-1:0] STEP_MAX = '1;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
  localparam int                   CMP_W    = (TIME_BITS > 20) ? TIME_BITS : 20;

  // Configuration registers.
  logic [7:0] even_on_ms, even_off_ms, uneven_on_ms, uneven_off_ms, gap_ms;
  logic       avoid_enable;

  // Move state.
  logic                 active, active_next;
  logic                 prev_left_gate, prev_right_gate;
  logic [STEP_BITS-1:0] left_steps, left_steps_next;
  logic [STEP_BITS-1:0] right_steps, right_steps_next;
  logic [TIME_BITS-1:0] elapsed_ms, elapsed_ms_next;
  logic [TIME_BITS-1:0] target_ms, target_ms_next;
  kind_t                pattern_kind, pattern_kind_next;
  phase_t               pattern_phase, pattern_phase_next;
  logic [7:0]           phase_timer, phase_timer_next;

  // Result fields computed for the item being accepted.
  logic ml_next, mr_next, busy_next, done_next;

  logic in_take;
  logic cfg_take;

  assign in_ready  = !out_valid || out_ready;
  assign in_take   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_take  = cfg_valid && cfg_ready;

  // Length of a phase given the on and off times of the current kind.
  function automatic logic [7:0] phase_len(phase_t ph, logic [7:0] on_len,
                                           logic [7:0] off_len, logic [7:0] gap_len);
    logic [7:0] len;
    len = 8'd0;
    unique case (ph)
      PH_ON:   len = on_len;
      PH_OFF:  len = off_len;
      PH_GAP:  len = gap_len;
      default: len = 8'd0;
    endcase
    return len;
  endfunction

  // First phase after the given one with a nonzero length, else the boundary.
  function automatic phase_t next_phase(phase_t from, logic [7:0] on_len,
                                        logic [7:0] off_len, logic [7:0] gap_len);
    phase_t nph;
    nph = PH_BOUNDARY;
    unique case (from)
      PH_BOUNDARY: begin
        if (on_len != 8'd0)       nph = PH_ON;
        else if (off_len != 8'd0) nph = PH_OFF;
        else if (gap_len != 8'd0) nph = PH_GAP;
      end
      PH_ON: begin
        if (off_len != 8'd0)      nph = PH_OFF;
        else if (gap_len != 8'd0) nph = PH_GAP;
      end
      PH_OFF: begin
        if (gap_len != 8'd0)      nph = PH_GAP;
      end
      default: nph = PH_BOUNDARY;
    endcase
    return nph;
  endfunction

  // Per-tick state update and result for one item.
  always_comb begin
    logic       blocked;
    logic       run;
    kind_t      k;
    phase_t     ph;
    logic [7:0] tmr;
    logic [7:0] on_len, off_len;

    blocked            = obstacle && avoid_enable;
    run                = 1'b0;
    k                  = pattern_kind;
    ph                 = pattern_phase;
    tmr                = phase_timer;
    on_len             = 8'd0;
    off_len            = 8'd0;
    active_next        = active;
    left_steps_next    = left_steps;
    right_steps_next   = right_steps;
    elapsed_ms_next    = elapsed_ms;
    target_ms_next     = target_ms;
    pattern_kind_next  = pattern_kind;
    pattern_phase_next = pattern_phase;
    phase_timer_next   = phase_timer;
    ml_next            = 1'b0;
    mr_next            = 1'b0;
    busy_next          = 1'b0;
    done_next          = 1'b0;

    if (op == OP_START) begin
      active_next        = 1'b1;
      left_steps_next    = '0;
      right_steps_next   = '0;
      elapsed_ms_next    = '0;
      target_ms_next     = (CMP_W'(duration_ms) > CMP_W'(TIME_MAX)) ? TIME_MAX
                                                                   : TIME_BITS'(duration_ms);
      pattern_kind_next  = KIND_NONE;
      pattern_phase_next = PH_BOUNDARY;
      phase_timer_next   = 8'd0;
      busy_next          = 1'b1;
    end else if (active) begin
      // Falling edges on the light gates count steps, saturating.
      if (prev_left_gate && !gate_left && left_steps != STEP_MAX)
        left_steps_next = left_steps + 1'b1;
      if (prev_right_gate && !gate_right && right_steps != STEP_MAX)
        right_steps_next = right_steps + 1'b1;

      run = 1'b1;
      if (pattern_phase == PH_BOUNDARY) begin
        if (elapsed_ms >= target_ms) begin
          // The move ends here; this tick does not count.
          active_next       = 1'b0;
          pattern_kind_next = KIND_NONE;
          phase_timer_next  = 8'd0;
          done_next         = 1'b1;
          run               = 1'b0;
        end else if (blocked) begin
          busy_next = 1'b1;
          run       = 1'b0;
        end else begin
          // Pick the pattern from the updated counts.
          if (left_steps_next < right_steps_next)      k = KIND_LEFT;
          else if (right_steps_next < left_steps_next) k = KIND_RIGHT;
          else                                         k = KIND_BOTH;
          pattern_kind_next = k;
        end
      end

      on_len  = (k == KIND_BOTH) ? even_on_ms : uneven_on_ms;
      off_len = (k == KIND_BOTH) ? even_off_ms : uneven_off_ms;

      if (run) begin
        busy_next = 1'b1;
        if (pattern_phase == PH_BOUNDARY) begin
          ph  = next_phase(PH_BOUNDARY, on_len, off_len, gap_ms);
          tmr = phase_len(ph, on_len, off_len, gap_ms);
        end
        if (ph == PH_BOUNDARY) begin
          // Empty pattern: one idle tick that still counts as elapsed.
          pattern_phase_next = PH_BOUNDARY;
          phase_timer_next   = 8'd0;
        end else begin
          if (ph == PH_ON && !blocked) begin
            ml_next = (k == KIND_LEFT) || (k == KIND_BOTH);
            mr_next = (k == KIND_RIGHT) || (k == KIND_BOTH);
          end
          if (tmr != 8'd0) tmr = tmr - 8'd1;
          if (tmr == 8'd0) begin
            ph  = next_phase(ph, on_len, off_len, gap_ms);
            tmr = phase_len(ph, on_len, off_len, gap_ms);
          end
          pattern_phase_next = ph;
          phase_timer_next   = tmr;
        end
        if (elapsed_ms != TIME_MAX) elapsed_ms_next = elapsed_ms + 1'b1;
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      even_on_ms    <= 8'd5;
      even_off_ms   <= 8'd20;
      uneven_on_ms  <= 8'd5;
      uneven_off_ms <= 8'd5;
      gap_ms        <= 8'd1;
      avoid_enable  <= 1'b1;
    end else if (cfg_take) begin
      unique case (cfg_index)
        REG_EVEN_ON:    even_on_ms    <= cfg_data;
        REG_EVEN_OFF:   even_off_ms   <= cfg_data;
        REG_UNEVEN_ON:  uneven_on_ms  <= cfg_data;
        REG_UNEVEN_OFF: uneven_off_ms <= cfg_data;
        REG_GAP:        gap_ms        <= cfg_data;
        REG_AVOID:      avoid_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Move state, updated on each accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      active          <= 1'b0;
      prev_left_gate  <= 1'b0;
      prev_right_gate <= 1'b0;
      left_steps      <= '0;
      right_steps     <= '0;
      elapsed_ms      <= '0;
      target_ms       <= '0;
      pattern_kind    <= KIND_NONE;
      pattern_phase   <= PH_BOUNDARY;
      phase_timer     <= 8'd0;
    end else if (in_take) begin
      active          <= active_next;
      prev_left_gate  <= gate_left;
      prev_right_gate <= gate_right;
      left_steps      <= left_steps_next;
      right_steps     <= right_steps_next;
      elapsed_ms      <= elapsed_ms_next;
      target_ms       <= target_ms_next;
      pattern_kind    <= pattern_kind_next;
      pattern_phase   <= pattern_phase_next;
      phase_timer     <= phase_timer_next;
    end
  end

  // Output register and its valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      motor_left  <= ml_next;
      motor_right <= mr_next;
      busy_res    <= busy_next;
      done_res    <= done_next;
    end
  end

  // A finishing result never drives a motor and never reports busy.
  a_done_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res && !motor_left && !motor_right)
    else $error("done result with motor drive or busy");

  // A motor is driven only while a move is in progress.
  a_motor_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && (motor_left || motor_right) |-> busy_res)
    else $error("motor driven without busy");

  // A start arms a fresh move with no elapsed time.
  a_start_arms: assert property (@(posedge clk) disable iff (rst)
    in_take && op == OP_START |=> active && elapsed_ms == '0 && pattern_phase == PH_BOUNDARY)
    else $error("start did not arm the move");

  // With no move active the pattern sits at its boundary.
  a_idle_boundary: assert property (@(posedge clk) disable iff (rst)
    !active |-> pattern_phase == PH_BOUNDARY)
    else $error("pattern running while idle");

endmodule

`default_nettype wire

>>> tb/sv/drive_pattern_checker.sv
// Checker for the balanced drive pulser: it watches the item, result and register
// write channels, predicts motor levels and move status, and counts mismatches.
// Depends on ebdp_pkg for the kind, phase, opcode and register index names.
`timescale 1ns / 100ps

module drive_pattern_checker
  import ebdp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic        op,
  input  wire logic [19:0] duration_ms,
  input  wire logic        gate_left,
  input  wire logic        gate_right,
  input  wire logic        obstacle,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic        motor_left,
  input  wire logic        motor_right,
  input  wire logic        busy_res,
  input  wire logic        done_res,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  output int               fault_count,
  output int               results_owed
);

  localparam int STEP_BITS = 16;
  localparam int TIME_BITS = 20;

  typedef struct packed {
    logic ml;
    logic mr;
    logic busy;
    logic done;
  } drive_levels_t;

  // Predicted register contents.
  logic [7:0] even_on, even_off, uneven_on, uneven_off, gap_len;
  logic       avoid_on;

  // Predicted move state.
  logic                 moving, last_gl, last_gr;
  logic [STEP_BITS-1:0] steps_l, steps_r;
  logic [TIME_BITS-1:0] run_ms, goal_ms;
  kind_t                kind;
  phase_t               phase;
  logic [7:0]           timer;

  drive_levels_t drive_levels_q[$];
  drive_levels_t want, got;
  int            faults;

  // Length of one phase of a pattern of the given kind.
  function automatic logic [7:0] phase_length(kind_t k, phase_t p);
    case (p)
      PH_ON:   return (k == KIND_BOTH) ? even_on : uneven_on;
      PH_OFF:  return (k == KIND_BOTH) ? even_off : uneven_off;
      PH_GAP:  return gap_len;
      default: return 8'd0;
    endcase
  endfunction

  // Next phase with a nonzero length, or the boundary when none is left.
  function automatic phase_t following_phase(kind_t k, phase_t from);
    phase_t p;
    p = from;
    repeat (3) begin
      case (p)
        PH_BOUNDARY: p = PH_ON;
        PH_ON:       p = PH_OFF;
        PH_OFF:      p = PH_GAP;
        default:     return PH_BOUNDARY;
      endcase
      if (phase_length(k, p) != 8'd0) return p;
    end
    return PH_BOUNDARY;
  endfunction

  // Put the predictor back into its reset state.
  task automatic clear_prediction();
    even_on    = 8'd5;
    even_off   = 8'd20;
    uneven_on  = 8'd5;
    uneven_off = 8'd5;
    gap_len    = 8'd1;
    avoid_on   = 1'b1;
    moving     = 1'b0;
    last_gl    = 1'b0;
    last_gr    = 1'b0;
    steps_l    = '0;
    steps_r    = '0;
    run_ms     = '0;
    goal_ms    = '0;
    kind       = KIND_NONE;
    phase      = PH_BOUNDARY;
    timer      = 8'd0;
    drive_levels_q.delete();
  endtask

  // Advance the predicted state by one item and queue the levels it produces.
  task automatic predict_drive(logic o, logic [19:0] dur, logic gl, logic gr, logic ob);
    drive_levels_t r;
    logic          blocked;
    logic          empty;
    blocked = ob & avoid_on;
    empty   = 1'b0;
    r.ml    = 1'b0;
    r.mr    = 1'b0;
    r.busy  = 1'b1;
    r.done  = 1'b0;
    if (o == OP_START) begin
      // A start clears the move and takes the gate levels as the new baseline.
      moving  = 1'b1;
      steps_l = '0;
      steps_r = '0;
      run_ms  = '0;
      goal_ms = dur;
      kind    = KIND_NONE;
      phase   = PH_BOUNDARY;
      timer   = 8'd0;
      last_gl = gl;
      last_gr = gr;
    end else if (!moving) begin
      last_gl = gl;
      last_gr = gr;
      r.busy  = 1'b0;
    end else begin
      // Count falling gate edges, saturating.
      if (last_gl && !gl && steps_l != '1) steps_l++;
      if (last_gr && !gr && steps_r != '1) steps_r++;
      last_gl = gl;
      last_gr = gr;
      if (phase == PH_BOUNDARY && run_ms >= goal_ms) begin
        moving = 1'b0;
        kind   = KIND_NONE;
        timer  = 8'd0;
        r.busy = 1'b0;
        r.done = 1'b1;
      end else if (!(phase == PH_BOUNDARY && blocked)) begin
        // At a boundary, pick the pattern from the step counts.
        if (phase == PH_BOUNDARY) begin
          if (steps_l < steps_r) kind = KIND_LEFT;
          else if (steps_r < steps_l) kind = KIND_RIGHT;
          else kind = KIND_BOTH;
          phase = following_phase(kind, PH_BOUNDARY);
          timer = phase_length(kind, phase);
          empty = (phase == PH_BOUNDARY);
        end
        if (!empty) begin
          if (phase == PH_ON && !blocked) begin
            r.ml = (kind == KIND_LEFT) || (kind == KIND_BOTH);
            r.mr = (kind == KIND_RIGHT) || (kind == KIND_BOTH);
          end
          if (timer != 8'd0) timer--;
          if (timer == 8'd0) begin
            phase = following_phase(kind, phase);
            timer = phase_length(kind, phase);
          end
        end
        if (run_ms != '1) run_ms++;
      end
    end
    drive_levels_q.push_back(r);
  endtask

  // Watch the three channels at each rising edge.
  always @(posedge clk) begin
    if (rst) begin
      clear_prediction();
      faults = 0;
    end else begin
      // Compare a result transaction with the oldest prediction.
      if (out_valid && out_ready) begin
        got.ml   = motor_left;
        got.mr   = motor_right;
        got.busy = busy_res;
        got.done = done_res;
        if (drive_levels_q.size() == 0) begin
          $display("%0t: unexpected result ml=%b mr=%b busy=%b done=%b", $time,
                   got.ml, got.mr, got.busy, got.done);
          faults++;
        end else begin
          want = drive_levels_q.pop_front();
          if (got !== want) begin
            $display("%0t: result mismatch, expected ml=%b mr=%b busy=%b done=%b, got ml=%b mr=%b busy=%b done=%b",
                     $time, want.ml, want.mr, want.busy, want.done,
                     got.ml, got.mr, got.busy, got.done);
            faults++;
          end
        end
      end
      // Register write transactions.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_EVEN_ON:    even_on    = cfg_data;
          REG_EVEN_OFF:   even_off   = cfg_data;
          REG_UNEVEN_ON:  uneven_on  = cfg_data;
          REG_UNEVEN_OFF: uneven_off = cfg_data;
          REG_GAP:        gap_len    = cfg_data;
          REG_AVOID:      avoid_on   = cfg_data[0];
          default: ;
        endcase
      end
      // Input item transactions.
      if (in_valid && in_ready) predict_drive(op, duration_ms, gate_left, gate_right, obstacle);
    end
    results_owed <= drive_levels_q.size();
    fault_count  <= faults;
  end

endmodule

>>> tb/sv/tb_top.sv
// Top of the drive pulser testbench: clock, reset, item and register stimulus,
// random idling on both channels, and the verdict.
// Depends on ebdp_pkg, the pulser RTL and drive_pattern_checker.
`timescale 1ns / 100ps

module tb_top;
  import ebdp_pkg::*;

  localparam int ITEM_TARGET = 1250;
  localparam int CALM_ITEMS  = 200;
  localparam int HOLD_CYCLES = 64;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        op = OP_TICK;
  logic [19:0] duration_ms = 20'd0;
  logic        gate_left = 1'b0;
  logic        gate_right = 1'b0;
  logic        obstacle = 1'b0;
  logic        out_ready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [2:0]  cfg_index = REG_EVEN_ON;
  logic [7:0]  cfg_data = 8'd0;
  logic        in_ready, out_valid, cfg_ready;
  logic        motor_left, motor_right, busy_res, done_res;
  int          fault_count, results_owed;

  // Stimulus state; the idle rate and the hold request are shared with the receiver.
  int   idle_pct = 0;
  logic hold_req = 1'b0;
  int   items_sent = 0;
  logic wheel_l = 1'b0;
  logic wheel_r = 1'b0;

  encoder_balanced_drive_pulser uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .op(op), .duration_ms(duration_ms),
    .gate_left(gate_left), .gate_right(gate_right), .obstacle(obstacle),
    .out_valid(out_valid), .out_ready(out_ready),
    .motor_left(motor_left), .motor_right(motor_right),
    .busy_res(busy_res), .done_res(done_res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  drive_pattern_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .op(op), .duration_ms(duration_ms),
    .gate_left(gate_left), .gate_right(gate_right), .obstacle(obstacle),
    .out_valid(out_valid), .out_ready(out_ready),
    .motor_left(motor_left), .motor_right(motor_right),
    .busy_res(busy_res), .done_res(done_res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fault_count(fault_count), .results_owed(results_owed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one item, with an optional idle burst first, and wait for its transaction.
  task automatic offer_item(logic o, logic [19:0] dur, logic gl, logic gr, logic ob);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    op          <= o;
    duration_ms <= dur;
    gate_left   <= gl;
    gate_right  <= gr;
    obstacle    <= ob;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic tick(logic gl, logic gr, logic ob);
    offer_item(OP_TICK, 20'($urandom), gl, gr, ob);
  endtask

  // Stop offering and wait until every predicted result has been taken.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  // Write all register addresses, including the two past the end of the map.
  task automatic load_settings(input logic [7:0] e_on, e_off, u_on, u_off, gap,
                               input logic avoid);
    logic [7:0] vals [8];
    vals[REG_EVEN_ON]    = e_on;
    vals[REG_EVEN_OFF]   = e_off;
    vals[REG_UNEVEN_ON]  = u_on;
    vals[REG_UNEVEN_OFF] = u_off;
    vals[REG_GAP]        = gap;
    vals[REG_AVOID]      = {7'($urandom), avoid};
    vals[6]              = 8'($urandom);
    vals[7]              = 8'($urandom);
    for (int i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_len();
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'hFF;
      2:       return 8'($urandom);
      default: return 8'($urandom_range(1, 6));
    endcase
  endfunction

  // One well-formed move: a start, then ticks with toggling gates and some obstacles.
  task automatic drive_move();
    logic [19:0] span;
    int          n, rate_l, rate_r, rate_ob;
    case ($urandom_range(0, 9))
      0:       span = 20'($urandom);
      1:       span = 20'd0;
      default: span = 20'($urandom_range(1, 60));
    endcase
    rate_l = $urandom_range(0, 60);
    rate_r = $urandom_range(0, 60);
    case ($urandom_range(0, 3))
      0:       rate_ob = 40;
      1:       rate_ob = 8;
      default: rate_ob = 0;
    endcase
    offer_item(OP_START, span, wheel_l, wheel_r, 1'($urandom));
    n = (span > 80) ? $urandom_range(5, 60) : int'(span) + $urandom_range(0, 12);
    repeat (n) begin
      if ($urandom_range(0, 99) < rate_l) wheel_l = ~wheel_l;
      if ($urandom_range(0, 99) < rate_r) wheel_r = ~wheel_r;
      tick(wheel_l, wheel_r, $urandom_range(0, 99) < rate_ob);
    end
  endtask

  // Short burst of unstructured items.
  task automatic drive_noise();
    repeat ($urandom_range(3, 12))
      offer_item($urandom_range(0, 7) == 0, 20'($urandom), 1'($urandom), 1'($urandom),
                 1'($urandom));
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    int phase_no;
    int segment_end;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset settings.
    tick(1'b1, 1'b1, 1'b1);                   // idle tick, gates recorded
    tick(1'b0, 1'b0, 1'b0);
    offer_item(OP_START, 20'd0, 1'b0, 1'b0, 1'b0);
    tick(1'b0, 1'b0, 1'b0);                   // zero duration finishes here
    offer_item(OP_START, 20'hFFFFF, 1'b1, 1'b0, 1'b1);
    tick(1'b0, 1'b0, 1'b0);                   // left edge: right motor pulses
    tick(1'b0, 1'b0, 1'b1);                   // obstacle inside a pattern
    tick(1'b0, 1'b1, 1'b0);
    tick(1'b0, 1'b0, 1'b0);                   // right edge evens the counts
    offer_item(OP_START, 20'd3, 1'b1, 1'b1, 1'b0);   // restart during a move
    tick(1'b1, 1'b1, 1'b1);                   // blocked at a boundary
    tick(1'b0, 1'b0, 1'b0);                   // both edges: even pattern
    tick(1'b0, 1'b0, 1'b1);
    tick(1'b0, 1'b0, 1'b0);
    settle();

    // Every phase zero and obstacles ignored: each tick is an empty pattern.
    load_settings(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
    offer_item(OP_START, 20'd2, 1'b0, 1'b0, 1'b0);
    tick(1'b0, 1'b0, 1'b1);
    tick(1'b0, 1'b0, 1'b1);
    tick(1'b0, 1'b0, 1'b1);                   // finish
    tick(1'b1, 1'b0, 1'b0);

    // Random part, in phases with their own settings.
    phase_no = 0;
    while (items_sent < ITEM_TARGET) begin
      settle();
      case (phase_no)
        0:       load_settings(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        1:       load_settings(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
        default: load_settings(pick_len(), pick_len(), pick_len(), pick_len(), pick_len(),
                               1'($urandom));
      endcase
      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 10;
        default: idle_pct = 30;
      endcase
      // Long receiver hold-off while items keep coming.
      if (phase_no == 2 || phase_no == 5) begin
        idle_pct = 0;
        hold_req = 1'b1;
      end
      segment_end = items_sent + 150;
      while (items_sent < segment_end && items_sent < ITEM_TARGET) begin
        if (items_sent >= ITEM_TARGET - CALM_ITEMS) idle_pct = 0;
        if ($urandom_range(0, 9) == 0) drive_noise();
        else drive_move();
      end
      phase_no++;
    end

    settle();
    repeat (4) @(posedge clk);
    if (fault_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
